// ===== rtl/sensor_reading_band_statistics_assert.svh =====
// Assertion macros shared by the sensor band statistics RTL.
// Holds no logic; it depends on nothing else.
`ifndef SENSOR_READING_BAND_STATISTICS_ASSERT_SVH
`define SENSOR_READING_BAND_STATISTICS_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define SRBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srbs assertion failed");

// The condition must hold in the cycle after the trigger.
`define SRBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srbs assertion failed");

`endif

// ===== rtl/srbs_pkg.sv =====
// Types and constants shared by the sensor band statistics modules.
// Depends on nothing; every other RTL module imports it.
`default_nettype none

package srbs_pkg;

    localparam int unsigned LIMIT_W = 15;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned SUM_W   = 25;

    // Restoring division takes one quotient bit per cycle.
    localparam int unsigned DIV_STEPS = SUM_W;
    localparam int unsigned STEP_W    = 5;

    // Register indexes on the APB port.
    localparam logic [1:0] REG_NORMAL   = 2'd0;
    localparam logic [1:0] REG_WARNING  = 2'd1;
    localparam logic [1:0] REG_CRITICAL = 2'd2;
    localparam logic [1:0] REG_ALARM    = 2'd3;

    // Register reset values, in 1/16 degree units.
    localparam logic [LIMIT_W-1:0] NORMAL_RESET   = 15'd464;
    localparam logic [LIMIT_W-1:0] WARNING_RESET  = 15'd704;
    localparam logic [LIMIT_W-1:0] CRITICAL_RESET = 15'd944;
    localparam logic [LIMIT_W-1:0] ALARM_RESET    = 15'd720;

    typedef struct packed {
        logic [LIMIT_W-1:0] normal_limit;
        logic [LIMIT_W-1:0] warning_limit;
        logic [LIMIT_W-1:0] critical_limit;
        logic [LIMIT_W-1:0] alarm_threshold;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/srbs_regs.sv =====
// APB register file holding the band limits and the alarm threshold.
// Depends on srbs_pkg for the register indexes and reset values.
`default_nettype none

module srbs_regs import srbs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg             r_cfg;
    logic [1:0]       reg_idx;
    logic             wr_en;
    logic [LIMIT_W-1:0] rd_val;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_limit    <= NORMAL_RESET;
            r_cfg.warning_limit   <= WARNING_RESET;
            r_cfg.critical_limit  <= CRITICAL_RESET;
            r_cfg.alarm_threshold <= ALARM_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NORMAL:   r_cfg.normal_limit    <= pwdata[LIMIT_W-1:0];
                REG_WARNING:  r_cfg.warning_limit   <= pwdata[LIMIT_W-1:0];
                REG_CRITICAL: r_cfg.critical_limit  <= pwdata[LIMIT_W-1:0];
                REG_ALARM:    r_cfg.alarm_threshold <= pwdata[LIMIT_W-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NORMAL:   rd_val = r_cfg.normal_limit;
            REG_WARNING:  rd_val = r_cfg.warning_limit;
            REG_CRITICAL: rd_val = r_cfg.critical_limit;
            REG_ALARM:    rd_val = r_cfg.alarm_threshold;
            default:      rd_val = '0;
        endcase
    end

    assign prdata = {{(32-LIMIT_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/srbs_ctrl.sv =====
// Controller: sequences accumulation, the average division and the result load.
// Depends on srbs_pkg for the command and status types.
`default_nettype none
`include "sensor_reading_band_statistics_assert.svh"

module srbs_ctrl import srbs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_last,
    output logic      o_ready,
    input  t_dp_sts   i_sts,
    output t_dp_cmd   o_cmd
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_ready      = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid && i_last) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `SRBS_ASSERT_NXT(a_last_starts_div, i_clk, i_rst_n, i_valid && o_ready && i_last, r_state == ST_INIT)
    `SRBS_ASSERT_IMP(a_step_in_range, i_clk, i_rst_n, r_state == ST_DIV, r_step <= LAST_STEP)
    `SRBS_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, o_cmd.load, i_sts.out_free)

endmodule

`default_nettype wire

// ===== rtl/srbs_dp.sv =====
// Datapath: running statistics, bit-serial average divider and result register.
// Depends on srbs_pkg for widths, the config struct and the command types.
`default_nettype none
`include "sensor_reading_band_statistics_assert.svh"

module srbs_dp import srbs_pkg::*; #(
    parameter int unsigned CNT_CAP = 1024,
    parameter int unsigned POS_CAP = 1023
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic        [15:0] i_reading,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [LIMIT_W-1:0]      o_min_reading,
    output logic [LIMIT_W-1:0]      o_max_reading,
    output logic [LIMIT_W-1:0]      o_avg_reading,
    output logic [CNT_W-1:0]        o_valid_count,
    output logic [CNT_W-1:0]        o_skipped_count,
    output logic [CNT_W-1:0]        o_normal_count,
    output logic [CNT_W-1:0]        o_warning_count,
    output logic [CNT_W-1:0]        o_critical_count,
    output logic [CNT_W-1:0]        o_shutdown_count,
    output logic [POS_W-1:0]        o_first_alarm_index,
    output logic                    o_alarm_seen,
    output logic                    o_batch_empty
);

    localparam logic [CNT_W-1:0] CAP  = CNT_W'(CNT_CAP);
    localparam logic [POS_W-1:0] PCAP = POS_W'(POS_CAP);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= CAP) ? CAP : v + 1'b1;
    endfunction

    // Running state of the current batch.
    logic [LIMIT_W-1:0] r_min, r_max;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_valid_total, r_skipped_total;
    logic [CNT_W-1:0]   r_band [4];
    logic [POS_W-1:0]   r_pos, r_alarm_idx;
    logic               r_alarm_flag;

    // Divider state: dividend shifts out as the quotient shifts in.
    logic [SUM_W-1:0]   r_div_num;
    logic [CNT_W-1:0]   r_div_rem;

    // Result register.
    logic               r_out_valid;
    logic [LIMIT_W-1:0] r_o_min, r_o_max, r_o_avg;
    logic [CNT_W-1:0]   r_o_valid, r_o_skipped;
    logic [CNT_W-1:0]   r_o_band [4];
    logic [POS_W-1:0]   r_o_alarm_idx;
    logic               r_o_alarm, r_o_empty;

    logic               rd_ok;
    logic [LIMIT_W-1:0] rd_val;
    logic               first_valid;
    logic [SUM_W:0]     sum_wide;
    logic [1:0]         band_sel;
    logic [CNT_W:0]     rem_sh;
    logic               rem_ge;
    logic [CNT_W-1:0]   rem_next;
    logic               batch_empty;
    logic [LIMIT_W-1:0] avg_val;

    assign rd_ok       = !i_reading[15];
    assign rd_val      = i_reading[LIMIT_W-1:0];
    assign first_valid = (r_valid_total == '0);
    assign sum_wide    = {1'b0, r_sum} + (SUM_W+1)'(rd_val);

    always_comb begin
        if (rd_val <= i_cfg.normal_limit) begin
            band_sel = 2'd0;
        end else if (rd_val <= i_cfg.warning_limit) begin
            band_sel = 2'd1;
        end else if (rd_val <= i_cfg.critical_limit) begin
            band_sel = 2'd2;
        end else begin
            band_sel = 2'd3;
        end
    end

    // One restoring division step.
    assign rem_sh   = {r_div_rem, r_div_num[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_valid_total});
    assign rem_next = rem_ge ? CNT_W'(rem_sh - {1'b0, r_valid_total}) : rem_sh[CNT_W-1:0];

    assign batch_empty = first_valid;
    assign avg_val     = (|r_div_num[SUM_W-1:LIMIT_W]) ? '1 : r_div_num[LIMIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_min           <= '0;
            r_max           <= '0;
            r_sum           <= '0;
            r_valid_total   <= '0;
            r_skipped_total <= '0;
            r_pos           <= '0;
            r_alarm_idx     <= '0;
            r_alarm_flag    <= 1'b0;
            for (int b = 0; b < 4; b++) begin
                r_band[b] <= '0;
            end
        end else if (i_cmd.accept) begin
            if (!rd_ok) begin
                r_skipped_total <= sat_inc(r_skipped_total);
            end else begin
                if (first_valid || rd_val < r_min) begin
                    r_min <= rd_val;
                end
                if (first_valid || rd_val > r_max) begin
                    r_max <= rd_val;
                end
                if (r_valid_total < CAP) begin
                    r_sum <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                end
                r_valid_total    <= sat_inc(r_valid_total);
                r_band[band_sel] <= sat_inc(r_band[band_sel]);
                if (rd_val >= i_cfg.alarm_threshold && !r_alarm_flag) begin
                    r_alarm_flag <= 1'b1;
                    r_alarm_idx  <= r_pos;
                end
            end
            if (r_pos < PCAP) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_div_num <= r_sum;
            r_div_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_div_num <= {r_div_num[SUM_W-2:0], rem_ge};
            r_div_rem <= rem_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_min       <= batch_empty ? '0 : r_min;
            r_o_max       <= batch_empty ? '0 : r_max;
            r_o_avg       <= batch_empty ? '0 : avg_val;
            r_o_valid     <= r_valid_total;
            r_o_skipped   <= r_skipped_total;
            r_o_alarm_idx <= r_alarm_flag ? r_alarm_idx : '0;
            r_o_alarm     <= r_alarm_flag;
            r_o_empty     <= batch_empty;
            for (int b = 0; b < 4; b++) begin
                r_o_band[b] <= r_band[b];
            end
        end
    end

    assign o_sts.out_free      = !r_out_valid || i_ready;
    assign o_valid             = r_out_valid;
    assign o_min_reading       = r_o_min;
    assign o_max_reading       = r_o_max;
    assign o_avg_reading       = r_o_avg;
    assign o_valid_count       = r_o_valid;
    assign o_skipped_count     = r_o_skipped;
    assign o_normal_count      = r_o_band[0];
    assign o_warning_count     = r_o_band[1];
    assign o_critical_count    = r_o_band[2];
    assign o_shutdown_count    = r_o_band[3];
    assign o_first_alarm_index = r_o_alarm_idx;
    assign o_alarm_seen        = r_o_alarm;
    assign o_batch_empty       = r_o_empty;

    `SRBS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_valid && o_batch_empty, o_avg_reading == '0 && o_max_reading == '0)
    `SRBS_ASSERT_IMP(a_min_le_max, i_clk, i_rst_n, o_valid && !o_batch_empty, o_min_reading <= o_max_reading)
    `SRBS_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, i_cmd.load, r_out_valid)

endmodule

`default_nettype wire

// ===== rtl/sensor_reading_band_statistics.sv =====
// Top level of the sensor band statistics block; uses srbs_pkg, srbs_regs, srbs_ctrl, srbs_dp.
// Throughput: one reading per cycle within a batch; after the last reading o_ready stays low
// while the bit-serial divider is set up and produces 25 quotient bits, and while the summary loads.
// The summary is valid once it is loaded into the output register; the load waits while the
// previous summary is still waiting there.
// Reset (synchronous, active low) clears all batch state and loads the register defaults.
`default_nettype none

module sensor_reading_band_statistics import srbs_pkg::*; #(
    parameter int unsigned MAX_READINGS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Reading channel.
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_reading,
    input  wire logic               i_last,
    // Summary channel.
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [LIMIT_W-1:0]      o_min_reading,
    output logic [LIMIT_W-1:0]      o_max_reading,
    output logic [LIMIT_W-1:0]      o_avg_reading,
    output logic [CNT_W-1:0]        o_valid_count,
    output logic [CNT_W-1:0]        o_skipped_count,
    output logic [CNT_W-1:0]        o_normal_count,
    output logic [CNT_W-1:0]        o_warning_count,
    output logic [CNT_W-1:0]        o_critical_count,
    output logic [CNT_W-1:0]        o_shutdown_count,
    output logic [POS_W-1:0]        o_first_alarm_index,
    output logic                    o_alarm_seen,
    output logic                    o_batch_empty,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    // Every count saturates at MAX_READINGS, but never beyond what an 11-bit field holds.
    // The batch position stops at MAX_READINGS - 1, or at the last index 10 bits can report.
    localparam int unsigned CNT_CAP = (MAX_READINGS > 2047) ? 2047 : MAX_READINGS;
    localparam int unsigned POS_CAP = (MAX_READINGS - 1 > 1023) ? 1023 : MAX_READINGS - 1;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // The user must change limits only while idle (unenforced); they feed the datapath directly.
    srbs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The controller takes a reading every cycle until the last one of a batch arrives,
    // then steps the divider and moves the finished summary into the output register.
    srbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The output register lets a new batch start streaming while the previous summary
    // still waits for its transfer.
    srbs_dp #(
        .CNT_CAP (CNT_CAP),
        .POS_CAP (POS_CAP)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_reading           (i_reading),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_min_reading       (o_min_reading),
        .o_max_reading       (o_max_reading),
        .o_avg_reading       (o_avg_reading),
        .o_valid_count       (o_valid_count),
        .o_skipped_count     (o_skipped_count),
        .o_normal_count      (o_normal_count),
        .o_warning_count     (o_warning_count),
        .o_critical_count    (o_critical_count),
        .o_shutdown_count    (o_shutdown_count),
        .o_first_alarm_index (o_first_alarm_index),
        .o_alarm_seen        (o_alarm_seen),
        .o_batch_empty       (o_batch_empty)
    );

endmodule

`default_nettype wire

// ===== tb/srbs_summary_checker.sv =====
`timescale 1ns / 100ps
// Summary checker for the sensor band statistics block: it watches the register port and both
// data channels, predicts every batch summary and compares each one field by field.
// Depends on srbs_pkg for field widths, register indexes and register reset values.

module srbs_summary_checker import srbs_pkg::*; #(
    parameter int unsigned MAX_READINGS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Reading channel, as seen at the block's ports.
    input  wire logic               i_rd_valid,
    input  wire logic               i_rd_ready,
    input  wire logic signed [15:0] i_reading,
    input  wire logic               i_last,
    // Summary channel, as seen at the block's ports.
    input  wire logic               i_sum_valid,
    input  wire logic               i_sum_ready,
    input  wire logic [LIMIT_W-1:0] i_min_reading,
    input  wire logic [LIMIT_W-1:0] i_max_reading,
    input  wire logic [LIMIT_W-1:0] i_avg_reading,
    input  wire logic [CNT_W-1:0]   i_valid_count,
    input  wire logic [CNT_W-1:0]   i_skipped_count,
    input  wire logic [CNT_W-1:0]   i_normal_count,
    input  wire logic [CNT_W-1:0]   i_warning_count,
    input  wire logic [CNT_W-1:0]   i_critical_count,
    input  wire logic [CNT_W-1:0]   i_shutdown_count,
    input  wire logic [POS_W-1:0]   i_first_alarm_index,
    input  wire logic               i_alarm_seen,
    input  wire logic               i_batch_empty,
    // Register port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    // Status for the testbench top.
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_summary_count
);

    typedef enum logic [1:0] {
        BAND_NORMAL,
        BAND_WARNING,
        BAND_CRITICAL,
        BAND_SHUTDOWN
    } t_band;

    typedef struct packed {
        logic [LIMIT_W-1:0] min_reading;
        logic [LIMIT_W-1:0] max_reading;
        logic [LIMIT_W-1:0] avg_reading;
        logic [CNT_W-1:0]   valid_count;
        logic [CNT_W-1:0]   skipped_count;
        logic [CNT_W-1:0]   normal_count;
        logic [CNT_W-1:0]   warning_count;
        logic [CNT_W-1:0]   critical_count;
        logic [CNT_W-1:0]   shutdown_count;
        logic [POS_W-1:0]   first_alarm_index;
        logic               alarm_seen;
        logic               batch_empty;
    } t_summary;

    // Counters stop at the parameter or at the field maximum, whichever comes first.
    localparam int unsigned COUNT_CAP = (MAX_READINGS > 2047) ? 2047 : MAX_READINGS;
    localparam int unsigned POS_CAP   = (MAX_READINGS - 1 > 1023) ? 1023 : MAX_READINGS - 1;
    localparam logic [SUM_W-1:0]   SUM_CAP = '1;
    localparam logic [LIMIT_W-1:0] AVG_CAP = '1;

    t_cfg               limits;
    logic [LIMIT_W-1:0] low_mark;
    logic [LIMIT_W-1:0] high_mark;
    logic [SUM_W-1:0]   sum_acc;
    logic [CNT_W-1:0]   valid_seen;
    logic [CNT_W-1:0]   errors_seen;
    logic [CNT_W-1:0]   band_seen [4];
    logic [POS_W-1:0]   next_pos;
    logic [POS_W-1:0]   alarm_pos;
    logic               alarm_hit;
    t_summary           summary_q [$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_summary_count = 0;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v >= COUNT_CAP) ? CNT_W'(COUNT_CAP) : v + 1'b1;
    endfunction

    task automatic clear_batch();
        low_mark    = '0;
        high_mark   = '0;
        sum_acc     = '0;
        valid_seen  = '0;
        errors_seen = '0;
        foreach (band_seen[b]) band_seen[b] = '0;
        next_pos    = '0;
        alarm_pos   = '0;
        alarm_hit   = 1'b0;
    endtask

    // Takes one reading into the batch state and queues the summary when it closes the batch.
    task automatic fold_reading(input logic signed [15:0] rd, input logic lst);
        logic [LIMIT_W-1:0] r;
        logic [SUM_W:0]     total;
        logic [SUM_W-1:0]   quotient;
        t_band              band;
        t_summary           s;
        r = rd[LIMIT_W-1:0];
        if (rd[15]) begin
            errors_seen = bump(errors_seen);
        end else begin
            if (valid_seen == 0) begin
                low_mark  = r;
                high_mark = r;
            end else begin
                if (r < low_mark) low_mark = r;
                if (r > high_mark) high_mark = r;
            end
            // Once the count has saturated the sum stops, so the mean stays consistent.
            if (valid_seen < COUNT_CAP) begin
                total   = {1'b0, sum_acc} + r;
                sum_acc = (total > SUM_CAP) ? SUM_CAP : total[SUM_W-1:0];
            end
            valid_seen = bump(valid_seen);
            if (r <= limits.normal_limit)        band = BAND_NORMAL;
            else if (r <= limits.warning_limit)  band = BAND_WARNING;
            else if (r <= limits.critical_limit) band = BAND_CRITICAL;
            else                                 band = BAND_SHUTDOWN;
            band_seen[band] = bump(band_seen[band]);
            if (r >= limits.alarm_threshold && !alarm_hit) begin
                alarm_hit = 1'b1;
                alarm_pos = next_pos;
            end
        end
        if (next_pos < POS_CAP) next_pos = next_pos + 1'b1;

        if (lst) begin
            s = '0;
            s.batch_empty = (valid_seen == 0);
            if (!s.batch_empty) begin
                quotient      = sum_acc / valid_seen;
                s.min_reading = low_mark;
                s.max_reading = high_mark;
                s.avg_reading = (quotient > AVG_CAP) ? AVG_CAP : quotient[LIMIT_W-1:0];
            end
            s.valid_count       = valid_seen;
            s.skipped_count     = errors_seen;
            s.normal_count      = band_seen[BAND_NORMAL];
            s.warning_count     = band_seen[BAND_WARNING];
            s.critical_count    = band_seen[BAND_CRITICAL];
            s.shutdown_count    = band_seen[BAND_SHUTDOWN];
            s.first_alarm_index = alarm_hit ? alarm_pos : '0;
            s.alarm_seen        = alarm_hit;
            summary_q.push_back(s);
            clear_batch();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count += 1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_summary want;
        if (!i_rst_n) begin
            clear_batch();
            limits.normal_limit    = NORMAL_RESET;
            limits.warning_limit   = WARNING_RESET;
            limits.critical_limit  = CRITICAL_RESET;
            limits.alarm_threshold = ALARM_RESET;
            summary_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_NORMAL:   limits.normal_limit    = pwdata[LIMIT_W-1:0];
                    REG_WARNING:  limits.warning_limit   = pwdata[LIMIT_W-1:0];
                    REG_CRITICAL: limits.critical_limit  = pwdata[LIMIT_W-1:0];
                    REG_ALARM:    limits.alarm_threshold = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_sum_valid && i_sum_ready) begin
                if (summary_q.size() == 0) begin
                    $error("summary transfer while no batch was closed");
                    o_fail_count += 1;
                end else begin
                    want = summary_q.pop_front();
                    check_field("min_reading", want.min_reading, i_min_reading);
                    check_field("max_reading", want.max_reading, i_max_reading);
                    check_field("avg_reading", want.avg_reading, i_avg_reading);
                    check_field("valid_count", want.valid_count, i_valid_count);
                    check_field("skipped_count", want.skipped_count, i_skipped_count);
                    check_field("normal_count", want.normal_count, i_normal_count);
                    check_field("warning_count", want.warning_count, i_warning_count);
                    check_field("critical_count", want.critical_count, i_critical_count);
                    check_field("shutdown_count", want.shutdown_count, i_shutdown_count);
                    check_field("first_alarm_index", want.first_alarm_index,
                                i_first_alarm_index);
                    check_field("alarm_seen", want.alarm_seen, i_alarm_seen);
                    check_field("batch_empty", want.batch_empty, i_batch_empty);
                    o_summary_count += 1;
                end
            end
            if (i_rd_valid && i_rd_ready) fold_reading(i_reading, i_last);
        end
        o_pending = summary_q.size();
    end

endmodule

// ===== tb/tb_sensor_reading_band_statistics.sv =====
`timescale 1ns / 100ps
// Testbench top for the sensor band statistics block: clock, reset, stimulus and verdict.
// Depends on srbs_pkg, the block itself and srbs_summary_checker, which does all checking.

module tb_sensor_reading_band_statistics import srbs_pkg::*; ();

    localparam int unsigned MAX_READINGS = 1024;
    // The slowest legal run is far below this: about 1650 readings, under a hundred
    // summaries and heavy idling in some phases.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // A summary leaves after its divide and load; this allows for that with a margin.
    localparam int unsigned SUMMARY_LATENCY = 40;
    localparam int unsigned PHASE_ITEMS = 70;
    localparam int unsigned NUM_PHASES = 7;

    // Directed batches: single readings at both extremes, two batches of sensor errors only,
    // every band edge with the alarm edge in between, a batch that opens with an error, and a
    // batch that never reaches the alarm threshold.
    localparam int DIRECTED_RD [20] = '{
        0, 32767, -32768, -1,
        464, 465, 704, 705, 944, 945, 719, 720, 721, -5, 100,
        -100, 300, 200,
        10, 20
    };
    // One bit per directed reading; a set bit closes the batch.
    localparam logic [19:0] DIRECTED_LAST = 20'hA400F;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [15:0]        i_reading;
    logic                      i_last;
    logic                      o_valid;
    logic                      i_ready;
    logic [LIMIT_W-1:0]        o_min_reading;
    logic [LIMIT_W-1:0]        o_max_reading;
    logic [LIMIT_W-1:0]        o_avg_reading;
    logic [CNT_W-1:0]          o_valid_count;
    logic [CNT_W-1:0]          o_skipped_count;
    logic [CNT_W-1:0]          o_normal_count;
    logic [CNT_W-1:0]          o_warning_count;
    logic [CNT_W-1:0]          o_critical_count;
    logic [CNT_W-1:0]          o_shutdown_count;
    logic [POS_W-1:0]          o_first_alarm_index;
    logic                      o_alarm_seen;
    logic                      o_batch_empty;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [3:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    int                        fail_count;
    int                        pending;
    int                        summary_count;
    int unsigned               send_idle_pct = 0;
    int unsigned               recv_stall_pct = 0;
    int unsigned               readings_sent = 0;
    int unsigned               settings_used = 0;
    int unsigned               cycle_count = 0;
    // The stimulus keeps its own copy of the limits so that readings can be aimed at them.
    logic [LIMIT_W-1:0]        limit_now [4];

    always #1 i_clk = ~i_clk;

    sensor_reading_band_statistics #(
        .MAX_READINGS(MAX_READINGS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_reading          (i_reading),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_min_reading      (o_min_reading),
        .o_max_reading      (o_max_reading),
        .o_avg_reading      (o_avg_reading),
        .o_valid_count      (o_valid_count),
        .o_skipped_count    (o_skipped_count),
        .o_normal_count     (o_normal_count),
        .o_warning_count    (o_warning_count),
        .o_critical_count   (o_critical_count),
        .o_shutdown_count   (o_shutdown_count),
        .o_first_alarm_index(o_first_alarm_index),
        .o_alarm_seen       (o_alarm_seen),
        .o_batch_empty      (o_batch_empty),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    srbs_summary_checker #(
        .MAX_READINGS(MAX_READINGS)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rd_valid         (i_valid),
        .i_rd_ready         (o_ready),
        .i_reading          (i_reading),
        .i_last             (i_last),
        .i_sum_valid        (o_valid),
        .i_sum_ready        (i_ready),
        .i_min_reading      (o_min_reading),
        .i_max_reading      (o_max_reading),
        .i_avg_reading      (o_avg_reading),
        .i_valid_count      (o_valid_count),
        .i_skipped_count    (o_skipped_count),
        .i_normal_count     (o_normal_count),
        .i_warning_count    (o_warning_count),
        .i_critical_count   (o_critical_count),
        .i_shutdown_count   (o_shutdown_count),
        .i_first_alarm_index(o_first_alarm_index),
        .i_alarm_seen       (o_alarm_seen),
        .i_batch_empty      (o_batch_empty),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_summary_count    (summary_count)
    );

    // The summary receiver decides afresh every cycle whether it stalls. With a stall rate of
    // zero, ready simply stays high.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count += 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One register write: a setup phase, then an access phase that completes at the edge
    // where pready is seen high. The wait at the end keeps back-to-back writes from lowering
    // and raising psel in the same time step.
    task automatic write_reg(input logic [1:0] idx, input logic [LIMIT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // Bits above the 15-bit limit are filled with noise; the register keeps only the
        // low bits.
        pwdata  <= {17'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input int unsigned n, input int unsigned w,
                              input int unsigned c, input int unsigned a);
        limit_now[REG_NORMAL]   = LIMIT_W'(n);
        limit_now[REG_WARNING]  = LIMIT_W'(w);
        limit_now[REG_CRITICAL] = LIMIT_W'(c);
        limit_now[REG_ALARM]    = LIMIT_W'(a);
        write_reg(REG_NORMAL, limit_now[REG_NORMAL]);
        write_reg(REG_WARNING, limit_now[REG_WARNING]);
        write_reg(REG_CRITICAL, limit_now[REG_CRITICAL]);
        write_reg(REG_ALARM, limit_now[REG_ALARM]);
        settings_used += 1;
    endtask

    // Presents one reading and returns at the edge where it is transferred. Valid is only
    // dropped when the sender chooses to idle, so a new reading follows the previous one
    // without a gap otherwise.
    task automatic send_reading(input logic signed [15:0] rd, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_reading <= rd;
        i_last    <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        readings_sent += 1;
    endtask

    // Stops sending and waits until every closed batch has produced its summary. The
    // hold-off afterwards is extra idle time before sending resumes.
    task automatic settle(input int unsigned holdoff);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (holdoff) @(posedge i_clk);
    endtask

    // Random readings: some sensor errors, many aimed at the current limits, some at the
    // extremes, and the rest spread over a low range and over the full positive range.
    function automatic logic signed [15:0] pick_reading();
        int unsigned k;
        int          v;
        k = $urandom_range(99);
        if (k < 12) begin
            return {1'b1, 15'($urandom())};
        end else if (k < 22) begin
            return $urandom_range(1) ? 16'sd0 : 16'sd32767;
        end else if (k < 55) begin
            v = int'(limit_now[$urandom_range(3)]) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 32767) v = 32767;
            return 16'(v);
        end else if (k < 80) begin
            return 16'($urandom_range(1200));
        end
        return 16'($urandom_range(32767));
    endfunction

    // Sends whole batches until the quota is reached. Most batches are short, a few run to
    // over a hundred readings, and some hold only sensor errors. Halfway through, the sender
    // holds back until the block has delivered every pending summary.
    task automatic run_batches(input int unsigned quota);
        int unsigned done;
        int unsigned len;
        int unsigned k;
        bit          all_errors;
        bit          paused;
        done   = 0;
        paused = 1'b0;
        while (done < quota) begin
            k = $urandom_range(99);
            if (k < 70)      len = $urandom_range(8, 1);
            else if (k < 95) len = $urandom_range(40, 9);
            else             len = $urandom_range(120, 41);
            all_errors = ($urandom_range(99) < 8);
            for (int i = 0; i < len; i++) begin
                send_reading(all_errors ? {1'b1, 15'($urandom())} : pick_reading(),
                             i == len - 1);
            end
            done += len;
            if (!paused && done >= quota / 2) begin
                settle(0);
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        int unsigned n;
        int unsigned w;
        int unsigned c;

        // Every input gets a known value before the first edge.
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_reading <= '0;
        i_last    <= 1'b0;
        i_ready   <= 1'b1;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening phase, without any idling: the reset limits are written back explicitly,
        // then the directed batches run.
        set_limits(NORMAL_RESET, WARNING_RESET, CRITICAL_RESET, ALARM_RESET);
        for (int i = 0; i < 20; i++) begin
            send_reading(16'(DIRECTED_RD[i]), DIRECTED_LAST[i]);
        end

        // A long batch of valid readings saturates the valid count, the normal band and the
        // position. A new minimum and a new maximum arrive after the sum has stopped, and the
        // maximum is also the first alarm, at the saturated position.
        for (int i = 0; i < 1036; i++) send_reading(16'($urandom_range(400, 1)), 1'b0);
        send_reading(16'sd0, 1'b0);
        send_reading(16'sd32767, 1'b0);
        send_reading(16'sd500, 1'b1);
        settle(SUMMARY_LATENCY);

        // Random phases. Each one pairs a limit setting with a way of idling: all limits at
        // zero and all at their maximum, limits out of order, ordered and unordered random
        // limits, and the reset values once more.
        for (int p = 1; p <= NUM_PHASES; p++) begin
            case (p)
                1: begin
                    set_limits(0, 0, 0, 0);
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2: begin
                    set_limits(32767, 32767, 32767, 32767);
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                3: begin
                    set_limits(3000, 1500, 600, 800);
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
                5: begin
                    set_limits($urandom_range(32767), $urandom_range(32767),
                               $urandom_range(32767), $urandom_range(32767));
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                6: begin
                    set_limits(NORMAL_RESET, WARNING_RESET, CRITICAL_RESET, ALARM_RESET);
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default: begin
                    // Ordered random limits, with the alarm between the normal limit and 300 above the critical limit.
                    n = $urandom_range(1500);
                    w = n + $urandom_range(1500);
                    c = w + $urandom_range(1500);
                    set_limits(n, w, c, $urandom_range(c + 300, n));
                    send_idle_pct  = (p == 7) ? 23 : 0;
                    recv_stall_pct = (p == 7) ? 23 : 0;
                end
            endcase
            run_batches(PHASE_ITEMS);
            settle(SUMMARY_LATENCY);
        end

        $display("Run covered %0d readings and %0d batch summaries under %0d limit settings,",
                 readings_sent, summary_count, settings_used);
        $display("with sender idling and receiver stalls at several rates.");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/srbs_pkg.sv
rtl/srbs_regs.sv
rtl/srbs_ctrl.sv
rtl/srbs_dp.sv
rtl/sensor_reading_band_statistics.sv
tb/srbs_summary_checker.sv
tb/tb_sensor_reading_band_statistics.sv
